/* src/pbfsp_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and helpers for the protobuf field stream parser
package pbfsp_pkg;

    localparam int OFFSET_BITS = 32;

    typedef enum logic [4:0] {
        PH_TAG   = 5'b00001,
        PH_VALUE = 5'b00010,
        PH_LEN   = 5'b00100,
        PH_SKIP  = 5'b01000,
        PH_DRAIN = 5'b10000
    } phase_t;

    localparam logic [2:0] WK_VARINT  = 3'd0;
    localparam logic [2:0] WK_FIXED64 = 3'd1;
    localparam logic [2:0] WK_LEN     = 3'd2;
    localparam logic [2:0] WK_FIXED32 = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNC     = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_UNKNOWN   = 2'd3;

    localparam logic [63:0] FIXED64_LEN = 64'd8;
    localparam logic [63:0] FIXED32_LEN = 64'd4;
    localparam logic [3:0]  LAST_GROUP  = 4'd9;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } in_word_t;

    typedef struct packed {
        logic [31:0] field_id;
        logic [2:0]  wire_kind;
        logic [63:0] field_value;
        logic [31:0] payload_offset;
        logic [1:0]  status_code;
        logic        message_done;
    } result_t;

    function automatic logic [31:0] to_offset(input logic [OFFSET_BITS-1:0] pos);
        logic [63:0] wide;
        wide = 64'(pos);
        return wide[31:0];
    endfunction

endpackage

/* src/pbfsp_in_stage.sv */
`timescale 1ns / 1ps
// input register for incoming message words
module pbfsp_in_stage
    import pbfsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_word,
    output logic     word_valid,
    output in_word_t word,
    input  logic     word_take
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    assign in_ready   = !valid_reg || word_take;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
        else if (word_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
        end
    end

endmodule

/* src/pbfsp_core.sv */
`timescale 1ns / 1ps
// wire format decode state and next-state logic
module pbfsp_core
    import pbfsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     word_valid,
    input  in_word_t word,
    input  logic     advance,
    output logic     word_take,
    output logic     res_valid,
    output result_t  res
);

    phase_t                 phase_reg, phase_next;
    logic [63:0]            accum_reg, accum_next;
    logic [3:0]             shift_reg, shift_next;
    logic [31:0]            id_reg, id_next;
    logic [2:0]             kind_reg, kind_next;
    logic [63:0]            left_reg, left_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;

    logic                   fire;
    logic [5:0]             shamt;
    logic [63:0]            group_bits;
    logic [63:0]            acc;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [63:0]            left_dec;

    assign fire      = word_valid && advance;
    assign word_take = fire;
    assign shamt     = 6'(7 * shift_reg);
    assign group_bits = (shift_reg <= LAST_GROUP) ? (64'(word.in_byte[6:0]) << shamt) : '0;
    assign acc       = accum_reg | group_bits;
    assign pos_inc   = pos_reg + OFFSET_BITS'(1);
    assign left_dec  = left_reg - 64'd1;

    always_comb
    begin
        phase_next = phase_reg;
        accum_next = accum_reg;
        shift_next = shift_reg;
        id_next    = id_reg;
        kind_next  = kind_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        res        = '0;
        res_valid  = 1'b0;

        if (fire)
        begin
            pos_next = pos_inc;
            unique case (phase_reg) inside
                PH_TAG, PH_VALUE, PH_LEN:
                begin
                    if (word.in_byte[7])
                    begin
                        accum_next = acc;
                        if (shift_reg >= LAST_GROUP)
                        begin
                            res_valid       = 1'b1;
                            res.status_code = ST_MALFORMED;
                            if (phase_reg != PH_TAG)
                            begin
                                res.field_id  = id_reg;
                                res.wire_kind = kind_reg;
                            end
                            phase_next = PH_DRAIN;
                        end
                        else
                        begin
                            shift_next = shift_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        accum_next = '0;
                        shift_next = '0;
                        if (phase_reg == PH_TAG)
                        begin
                            id_next    = acc[34:3];
                            kind_next  = acc[2:0];
                            start_next = pos_inc;
                            unique case (acc[2:0])
                                WK_VARINT:  phase_next = PH_VALUE;
                                WK_LEN:     phase_next = PH_LEN;
                                WK_FIXED64:
                                begin
                                    accum_next = FIXED64_LEN;
                                    left_next  = FIXED64_LEN;
                                    phase_next = PH_SKIP;
                                end
                                WK_FIXED32:
                                begin
                                    accum_next = FIXED32_LEN;
                                    left_next  = FIXED32_LEN;
                                    phase_next = PH_SKIP;
                                end
                                default:
                                begin
                                    res_valid       = 1'b1;
                                    res.field_id    = acc[34:3];
                                    res.wire_kind   = acc[2:0];
                                    res.status_code = ST_UNKNOWN;
                                    phase_next      = PH_DRAIN;
                                end
                            endcase
                        end
                        else if (phase_reg == PH_VALUE)
                        begin
                            res_valid       = 1'b1;
                            res.field_id    = id_reg;
                            res.wire_kind   = kind_reg;
                            res.field_value = acc;
                            res.status_code = ST_OK;
                            phase_next      = PH_TAG;
                        end
                        else
                        begin
                            start_next = pos_inc;
                            if (acc == 64'd0)
                            begin
                                res_valid          = 1'b1;
                                res.field_id       = id_reg;
                                res.wire_kind      = kind_reg;
                                res.payload_offset = to_offset(pos_inc);
                                res.status_code    = ST_OK;
                                phase_next         = PH_TAG;
                            end
                            else
                            begin
                                accum_next = acc;
                                left_next  = acc;
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                end
                PH_SKIP:
                begin
                    left_next = left_dec;
                    if (left_dec == 64'd0)
                    begin
                        res_valid          = 1'b1;
                        res.field_id       = id_reg;
                        res.wire_kind      = kind_reg;
                        res.field_value    = accum_reg;
                        res.payload_offset = to_offset(start_reg);
                        res.status_code    = ST_OK;
                        accum_next         = '0;
                        phase_next         = PH_TAG;
                    end
                end
                PH_DRAIN:
                begin
                    phase_next = PH_DRAIN;
                end
                default:
                begin
                    phase_next = PH_DRAIN;
                end
            endcase

            if (word.is_last)
            begin
                if (res_valid)
                begin
                    res.message_done = 1'b1;
                end
                else if (phase_reg != PH_DRAIN)
                begin
                    res_valid        = 1'b1;
                    res.status_code  = ST_TRUNC;
                    res.message_done = 1'b1;
                    if (phase_next != PH_TAG)
                    begin
                        res.field_id  = id_next;
                        res.wire_kind = kind_next;
                    end
                end
                phase_next = PH_TAG;
                accum_next = '0;
                shift_next = '0;
                id_next    = '0;
                kind_next  = '0;
                left_next  = '0;
                pos_next   = '0;
                start_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            accum_reg <= '0;
            shift_reg <= '0;
            id_reg    <= '0;
            kind_reg  <= '0;
            left_reg  <= '0;
            pos_reg   <= '0;
            start_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            shift_reg <= shift_next;
            id_reg    <= id_next;
            kind_reg  <= kind_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
        end
    end

endmodule

/* src/pbfsp_out_stage.sv */
`timescale 1ns / 1ps
// result register for decoded field words
module pbfsp_out_stage
    import pbfsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_valid,
    input  result_t res,
    output logic    advance,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg;
    logic    valid_next;
    logic    load;
    result_t res_reg;

    assign advance   = !valid_reg || out_ready;
    assign load      = advance && res_valid;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

/* src/protobuf_field_stream_parser.sv */
`timescale 1ns / 1ps
// top level of the protobuf wire format field decoder
//
//   channel   direction   handshake             word
//   in        sink        in_valid / in_ready   in_byte, is_last
//   out       source      out_valid / out_ready field_id, wire_kind, field_value,
//                                               payload_offset, status_code, message_done
//
// one byte per cycle unless the out channel stalls; a byte passes input register,
// decode logic and result register in that order, and its result is shown from the result register
// rate is set by the single decode step between the two registers
// reset returns the decoder to reading a tag at offset zero
// a stalled out channel holds the result register and then the input register
module protobuf_field_stream_parser
    import pbfsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] field_id,
    output logic [2:0]  wire_kind,
    output logic [63:0] field_value,
    output logic [31:0] payload_offset,
    output logic [1:0]  status_code,
    output logic        message_done
);

    in_word_t in_word;
    in_word_t word;
    logic     word_valid;
    logic     word_take;
    logic     advance;
    logic     res_valid;
    result_t  res;
    result_t  out_res;

    assign in_word.in_byte = in_byte;
    assign in_word.is_last = is_last;

    pbfsp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .word_valid (word_valid),
        .word       (word),
        .word_take  (word_take)
    );

    pbfsp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word       (word),
        .advance    (advance),
        .word_take  (word_take),
        .res_valid  (res_valid),
        .res        (res)
    );

    pbfsp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign field_id       = out_res.field_id;
    assign wire_kind      = out_res.wire_kind;
    assign field_value    = out_res.field_value;
    assign payload_offset = out_res.payload_offset;
    assign status_code    = out_res.status_code;
    assign message_done   = out_res.message_done;

endmodule
